### rtl/ascii_decimal_multiplier_top_macros.svh
// Assertion macros for the RTL file that checks itself.
`ifndef ASCII_DECIMAL_MULTIPLIER_TOP_MACROS_SVH
`define ASCII_DECIMAL_MULTIPLIER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset.
`define ADM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// Check that a consequent holds in the cycle of its antecedent.
`define ADM_ASSERT_IMPLY(label, ante, cons, msg) \
  `ADM_ASSERT(label, (ante) |-> (cons), msg)
// Check that a consequent holds in the cycle after its antecedent.
`define ADM_ASSERT_NEXT(label, ante, cons, msg) \
  `ADM_ASSERT(label, (ante) |=> (cons), msg)
`else
`define ADM_ASSERT(label, prop, msg)
`define ADM_ASSERT_IMPLY(label, ante, cons, msg)
`define ADM_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### rtl/adm_pkg.sv
`default_nettype none

package adm_pkg;

  // Operand format
  localparam int DIGITS_IN_DEF      = 3;
  localparam int FIELDS_PER_OPERAND = 3;
  localparam int CHAR_W             = 8;
  localparam int DIGIT_CHAR_W       = 6;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'd57;

  // Divide by ten as multiply by reciprocal, exact for values below 2**22
  localparam int                     DIV_SHIFT   = 23;
  localparam int                     DIV_MAGIC_W = 20;
  localparam logic [DIV_MAGIC_W-1:0] DIV_MAGIC   = 20'd838861;

  // Microcode addresses
  typedef logic [2:0] upc_t;
  localparam upc_t STEP_WAIT  = 3'd0;
  localparam upc_t STEP_CHECK = 3'd1;
  localparam upc_t STEP_CONV  = 3'd2;
  localparam upc_t STEP_MUL   = 3'd3;
  localparam upc_t STEP_DIV   = 3'd4;
  localparam upc_t STEP_EMIT  = 3'd5;
  localparam upc_t STEP_ERR   = 3'd6;

  // Sequencer branch conditions
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_IN,
    COND_BAD,
    COND_CONV,
    COND_DIV,
    COND_EMIT,
    COND_OUT,
    COND_JUMP
  } cond_e;

  typedef struct packed {
    logic  in_ready;
    logic  clr;
    logic  conv;
    logic  mul;
    logic  div;
    logic  emit;
    logic  err;
    cond_e cond;
    upc_t  target;
  } ucode_t;

  typedef struct packed {
    logic in_beat;
    logic bad;
    logic conv_more;
    logic quot_nz;
    logic out_load;
    logic emit_last;
  } status_t;

  // Control store: one word per step
  function automatic ucode_t ucode_rom(input upc_t pc);
    ucode_t w;
    w        = '0;
    w.cond   = COND_JUMP;
    w.target = STEP_WAIT;
    case (pc)
      STEP_WAIT: begin
        w.in_ready = 1'b1;
        w.cond     = COND_IN;
      end
      STEP_CHECK: begin
        w.clr    = 1'b1;
        w.cond   = COND_BAD;
        w.target = STEP_ERR;
      end
      STEP_CONV: begin
        w.conv   = 1'b1;
        w.cond   = COND_CONV;
        w.target = STEP_CONV;
      end
      STEP_MUL: begin
        w.mul  = 1'b1;
        w.cond = COND_NEXT;
      end
      STEP_DIV: begin
        w.div    = 1'b1;
        w.cond   = COND_DIV;
        w.target = STEP_DIV;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_EMIT;
        w.target = STEP_WAIT;
      end
      STEP_ERR: begin
        w.err    = 1'b1;
        w.cond   = COND_OUT;
        w.target = STEP_WAIT;
      end
      default: ;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/ascii_decimal_multiplier_top.sv
// Channel | Handshake           | Beat contents
// --------+---------------------+------------------------------------------------
// in      | in_valid/in_ready   | a_hundreds..a_units, b_hundreds..b_units (ASCII)
// out     | out_valid/out_ready | digit_char, last_digit, bad_input
//
// One item at a time. After acceptance: one check step, DIGITS_IN conversion
// steps, one multiply step, k divide-by-ten steps and k emit steps, where k is
// the number of product digits (1 to 2*DIGITS_IN); the next item can be taken
// in the cycle after the last digit is loaded. A bad item goes from the check
// step to one error step. The shared divide-by-ten step and the one-digit
// output register set the throughput. Reset puts the sequencer on its wait step
// and empties the output register. A stall on out holds the emit or error step.
`default_nettype none

`include "ascii_decimal_multiplier_top_macros.svh"

module ascii_decimal_multiplier_top #(
  parameter int DIGITS_IN = adm_pkg::DIGITS_IN_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [adm_pkg::CHAR_W-1:0]       a_hundreds_i,
  input  logic [adm_pkg::CHAR_W-1:0]       a_tens_i,
  input  logic [adm_pkg::CHAR_W-1:0]       a_units_i,
  input  logic [adm_pkg::CHAR_W-1:0]       b_hundreds_i,
  input  logic [adm_pkg::CHAR_W-1:0]       b_tens_i,
  input  logic [adm_pkg::CHAR_W-1:0]       b_units_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [adm_pkg::DIGIT_CHAR_W-1:0] digit_char_o,
  output logic                             last_digit_o,
  output logic                             bad_input_o
);
  import adm_pkg::*;

  // Operands have three fields each
  localparam int UsedDigits = (DIGITS_IN < 1) ? 1 :
                              (DIGITS_IN > FIELDS_PER_OPERAND) ? FIELDS_PER_OPERAND :
                              DIGITS_IN;

  logic [CHAR_W-1:0] a_chars [FIELDS_PER_OPERAND];
  logic [CHAR_W-1:0] b_chars [FIELDS_PER_OPERAND];
  ucode_t            ctrl;
  status_t           status;

  // Order fields most significant first
  assign a_chars[0] = a_hundreds_i;
  assign a_chars[1] = a_tens_i;
  assign a_chars[2] = a_units_i;
  assign b_chars[0] = b_hundreds_i;
  assign b_chars[1] = b_tens_i;
  assign b_chars[2] = b_units_i;

  assign in_ready_o = ctrl.in_ready;

  adm_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  adm_datapath #(
    .N (UsedDigits)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .status_o     (status),
    .in_valid_i   (in_valid_i),
    .a_chars_i    (a_chars),
    .b_chars_i    (b_chars),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o),
    .bad_input_o  (bad_input_o)
  );

  // An error beat is a lone, last beat carrying zero
  `ADM_ASSERT_IMPLY(err_beat_a,
                    out_valid_o && bad_input_o,
                    last_digit_o && (digit_char_o == '0),
                    "error beat not last or not zero")
  // A good beat carries an ASCII digit
  `ADM_ASSERT_IMPLY(digit_range_a,
                    out_valid_o && !bad_input_o,
                    (digit_char_o >= CHAR_ZERO[DIGIT_CHAR_W-1:0]) &&
                    (digit_char_o <= CHAR_NINE[DIGIT_CHAR_W-1:0]),
                    "digit out of range")
  // Taking a beat starts the work and drops ready
  `ADM_ASSERT_NEXT(one_item_a,
                   in_valid_i && in_ready_o,
                   !in_ready_o,
                   "ready held after input beat")

endmodule

`default_nettype wire

### rtl/adm_seq.sv
`default_nettype none

module adm_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  adm_pkg::status_t status_i,
  output adm_pkg::ucode_t  ctrl_o
);
  import adm_pkg::*;

  upc_t   pc_q, pc_d;
  ucode_t word;

  // Fetch the control word of the current step
  assign word   = ucode_rom(pc_q);
  assign ctrl_o = word;

  // Pick the next step: advance, hold or branch
  always_comb begin
    pc_d = pc_q;
    case (word.cond)
      COND_NEXT: pc_d = pc_q + 3'd1;
      COND_IN:   if (status_i.in_beat) pc_d = pc_q + 3'd1;
      COND_BAD:  pc_d = status_i.bad ? word.target : pc_q + 3'd1;
      COND_CONV: pc_d = status_i.conv_more ? word.target : pc_q + 3'd1;
      COND_DIV:  pc_d = status_i.quot_nz ? word.target : pc_q + 3'd1;
      COND_EMIT: if (status_i.out_load && status_i.emit_last) pc_d = word.target;
      COND_OUT:  if (status_i.out_load) pc_d = word.target;
      COND_JUMP: pc_d = word.target;
      default:   pc_d = STEP_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

### rtl/adm_datapath.sv
`default_nettype none

module adm_datapath #(
  parameter int N = adm_pkg::DIGITS_IN_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  adm_pkg::ucode_t                  ctrl_i,
  output adm_pkg::status_t                 status_o,
  input  logic                             in_valid_i,
  input  logic [adm_pkg::CHAR_W-1:0]       a_chars_i [adm_pkg::FIELDS_PER_OPERAND],
  input  logic [adm_pkg::CHAR_W-1:0]       b_chars_i [adm_pkg::FIELDS_PER_OPERAND],
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [adm_pkg::DIGIT_CHAR_W-1:0] digit_char_o,
  output logic                             last_digit_o,
  output logic                             bad_input_o
);
  import adm_pkg::*;

  localparam int OpW      = $clog2(10 ** N);
  localparam int ProdW    = $clog2(10 ** (2 * N));
  localparam int QuotW    = ProdW - 3;
  localparam int RecipW   = ProdW + DIV_MAGIC_W;
  localparam int BufDepth = 2 * N;
  localparam int BufIdxW  = $clog2(BufDepth);
  localparam int CntW     = $clog2(BufDepth + 1);
  localparam int DigIdxW  = (N > 1) ? $clog2(N) : 1;

  logic [3:0]       dig_a_q [N];
  logic [3:0]       dig_b_q [N];
  logic             bad_q;
  logic [OpW-1:0]   acc_a_q, acc_b_q;
  logic [ProdW-1:0] prod_q;
  logic [CntW-1:0]  cnt_q;
  logic [3:0]       dbuf_q [BufDepth];

  logic                    out_valid_q;
  logic [DIGIT_CHAR_W-1:0] out_char_q;
  logic                    out_last_q;
  logic                    out_bad_q;

  logic                 in_beat;
  logic                 bad_in;
  logic [3:0]           cur_a, cur_b;
  logic [OpW-1:0]       acc_a_d, acc_b_d;
  logic [2*OpW-1:0]     mul_full;
  logic [RecipW-1:0]    recip;
  logic [QuotW-1:0]     quot;
  logic [ProdW-1:0]     quot_ext, quot_x10, rem_full;
  logic [3:0]           rem;
  logic [CntW-1:0]      cnt_m1;
  logic [3:0]           emit_digit;
  logic                 emit_last;
  logic                 out_load;

  assign in_beat = in_valid_i & ctrl_i.in_ready;

  // Flag any used character outside '0'..'9'
  always_comb begin
    bad_in = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (a_chars_i[i] < CHAR_ZERO || a_chars_i[i] > CHAR_NINE) bad_in = 1'b1;
      if (b_chars_i[i] < CHAR_ZERO || b_chars_i[i] > CHAR_NINE) bad_in = 1'b1;
    end
  end

  // Decimal to binary: one digit of each operand per step
  assign cur_a   = dig_a_q[cnt_q[DigIdxW-1:0]];
  assign cur_b   = dig_b_q[cnt_q[DigIdxW-1:0]];
  assign acc_a_d = (acc_a_q << 3) + (acc_a_q << 1) + {{(OpW-4){1'b0}}, cur_a};
  assign acc_b_d = (acc_b_q << 3) + (acc_b_q << 1) + {{(OpW-4){1'b0}}, cur_b};

  assign mul_full = acc_a_q * acc_b_q;

  // Divide by ten through the reciprocal; remainder from quotient times ten
  assign recip    = prod_q * DIV_MAGIC;
  assign quot     = recip[DIV_SHIFT +: QuotW];
  assign quot_ext = {3'b000, quot};
  assign quot_x10 = (quot_ext << 3) + (quot_ext << 1);
  assign rem_full = prod_q - quot_x10;
  assign rem      = rem_full[3:0];

  // Digits leave most significant first, from the top of the buffer
  assign cnt_m1     = cnt_q - {{(CntW-1){1'b0}}, 1'b1};
  assign emit_digit = dbuf_q[cnt_m1[BufIdxW-1:0]];
  assign emit_last  = (cnt_q == {{(CntW-1){1'b0}}, 1'b1});
  assign out_load   = (ctrl_i.emit | ctrl_i.err) & (~out_valid_q | out_ready_i);

  assign status_o.in_beat   = in_beat;
  assign status_o.bad       = bad_q;
  assign status_o.conv_more = (cnt_q != CntW'(N - 1));
  assign status_o.quot_nz   = (quot != '0);
  assign status_o.out_load  = out_load;
  assign status_o.emit_last = emit_last;

  // Step counter: shared by conversion, division and emission
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.clr || ctrl_i.mul) begin
      cnt_q <= '0;
    end else if (ctrl_i.conv || ctrl_i.div) begin
      cnt_q <= cnt_q + {{(CntW-1){1'b0}}, 1'b1};
    end else if (ctrl_i.emit && out_load) begin
      cnt_q <= cnt_m1;
    end
  end

  // Capture the beat, then run the arithmetic steps
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      for (int i = 0; i < N; i++) begin
        dig_a_q[i] <= a_chars_i[i][3:0];
        dig_b_q[i] <= b_chars_i[i][3:0];
      end
      bad_q <= bad_in;
    end
    if (ctrl_i.clr) begin
      acc_a_q <= '0;
      acc_b_q <= '0;
    end else if (ctrl_i.conv) begin
      acc_a_q <= acc_a_d;
      acc_b_q <= acc_b_d;
    end
    if (ctrl_i.mul) begin
      prod_q <= mul_full[ProdW-1:0];
    end else if (ctrl_i.div) begin
      prod_q <= quot_ext;
    end
    if (ctrl_i.div) begin
      dbuf_q[cnt_q[BufIdxW-1:0]] <= rem;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (ctrl_i.err) begin
        out_char_q <= '0;
        out_last_q <= 1'b1;
        out_bad_q  <= 1'b1;
      end else begin
        out_char_q <= CHAR_ZERO[DIGIT_CHAR_W-1:0] + {2'b00, emit_digit};
        out_last_q <= emit_last;
        out_bad_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = out_char_q;
  assign last_digit_o = out_last_q;
  assign bad_input_o  = out_bad_q;

endmodule

`default_nettype wire

### test/tb_ascii_decimal_multiplier_top.sv
`timescale 1ns / 100ps

module tb_ascii_decimal_multiplier_top;
  import adm_pkg::*;

  localparam int OPERAND_DIGITS = DIGITS_IN_DEF;
  localparam int DECIMAL_BASE   = 10;
  localparam int MAX_DIGITS     = 2 * FIELDS_PER_OPERAND;
  localparam int RANDOM_ITEMS   = 400;
  localparam int DIRECTED_ITEMS = 22;
  localparam int LONG_HOLD      = 400;
  localparam int HOLD_AFTER     = 100;
  localparam int DRAIN_CYCLES   = 40;
  localparam int REPORT_LIMIT   = 10;

  // Operand characters, [5] = a_hundreds down to [0] = b_units
  typedef logic [5:0][CHAR_W-1:0] operand_chars_t;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_DIGITS,
    ROW_ERROR
  } row_kind_e;

  typedef struct packed {
    row_kind_e      kind;
    operand_chars_t chars;
    logic [47:0]    digits;
  } stim_row_t;

  typedef struct packed {
    logic [DIGIT_CHAR_W-1:0] digit;
    logic                    last;
    logic                    bad;
  } product_beat_t;

  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    in_valid_i   = 1'b0;
  logic                    out_ready_i  = 1'b0;
  logic [CHAR_W-1:0]       a_hundreds_i = '0;
  logic [CHAR_W-1:0]       a_tens_i     = '0;
  logic [CHAR_W-1:0]       a_units_i    = '0;
  logic [CHAR_W-1:0]       b_hundreds_i = '0;
  logic [CHAR_W-1:0]       b_tens_i     = '0;
  logic [CHAR_W-1:0]       b_units_i    = '0;
  logic                    in_ready_o;
  logic                    out_valid_o;
  logic [DIGIT_CHAR_W-1:0] digit_char_o;
  logic                    last_digit_o;
  logic                    bad_input_o;

  product_beat_t pending_digits[$];
  int            mismatches  = 0;
  int            beats_seen  = 0;
  int            bad_beats   = 0;
  int            items_sent  = 0;

  // Hand-typed results for the extremes, bad-character items, and items to predict
  stim_row_t directed_rows [DIRECTED_ITEMS] = '{
    '{ROW_DIGITS,  "000000",                    "0"},
    '{ROW_DIGITS,  "999999",                    "998001"},
    '{ROW_DIGITS,  "001001",                    "1"},
    '{ROW_DIGITS,  "100100",                    "10000"},
    '{ROW_DIGITS,  "000999",                    "0"},
    '{ROW_DIGITS,  "999001",                    "999"},
    '{ROW_DIGITS,  "500200",                    "100000"},
    '{ROW_DIGITS,  "007008",                    "56"},
    '{ROW_ERROR,   {8'h2F, "00", "000"},        '0},
    '{ROW_ERROR,   {8'h3A, "00", "000"},        '0},
    '{ROW_ERROR,   {"000", "00", 8'h3A},        '0},
    '{ROW_ERROR,   {"0", 8'h00, "0", "000"},    '0},
    '{ROW_ERROR,   {"000", 8'hFF, "00"},        '0},
    '{ROW_ERROR,   {6{8'hFF}},                  '0},
    '{ROW_ERROR,   {6{8'h00}},                  '0},
    '{ROW_ERROR,   {"12", 8'h80, "456"},        '0},
    '{ROW_ERROR,   {"999", "9", 8'h40, "9"},    '0},
    '{ROW_PREDICT, "123456",                    '0},
    '{ROW_PREDICT, "050020",                    '0},
    '{ROW_PREDICT, "012034",                    '0},
    '{ROW_PREDICT, "316316",                    '0},
    '{ROW_PREDICT, "099101",                    '0}
  };

  ascii_decimal_multiplier_top #(
    .DIGITS_IN(OPERAND_DIGITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .a_hundreds_i(a_hundreds_i),
    .a_tens_i    (a_tens_i),
    .a_units_i   (a_units_i),
    .b_hundreds_i(b_hundreds_i),
    .b_tens_i    (b_tens_i),
    .b_units_i   (b_units_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .digit_char_o(digit_char_o),
    .last_digit_o(last_digit_o),
    .bad_input_o (bad_input_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void queue_digit(input logic [DIGIT_CHAR_W-1:0] digit,
                                      input logic last, input logic bad);
    product_beat_t beat;
    beat.digit = digit;
    beat.last  = last;
    beat.bad   = bad;
    pending_digits.push_back(beat);
  endfunction

  // Check the used characters, multiply, and queue the product digits MSB first
  function automatic void predict_product(input operand_chars_t chars);
    int unsigned op_a, op_b, prod;
    int          rev [MAX_DIGITS];
    int          used, count;
    logic        bad;
    logic [CHAR_W-1:0] ch_a, ch_b;
    used = OPERAND_DIGITS;
    if (used < 1) used = 1;
    if (used > FIELDS_PER_OPERAND) used = FIELDS_PER_OPERAND;
    op_a = 0;
    op_b = 0;
    bad  = 1'b0;
    for (int i = 0; i < used; i++) begin
      ch_a = chars[5 - i];
      ch_b = chars[2 - i];
      if (ch_a < CHAR_ZERO || ch_a > CHAR_NINE) bad = 1'b1;
      if (ch_b < CHAR_ZERO || ch_b > CHAR_NINE) bad = 1'b1;
      op_a = op_a * DECIMAL_BASE + (32'(ch_a) - 32'(CHAR_ZERO));
      op_b = op_b * DECIMAL_BASE + (32'(ch_b) - 32'(CHAR_ZERO));
    end
    if (bad) begin
      queue_digit('0, 1'b1, 1'b1);
      return;
    end
    prod  = op_a * op_b;
    count = 0;
    do begin
      rev[count] = prod % DECIMAL_BASE;
      prod       = prod / DECIMAL_BASE;
      count++;
    end while (prod != 0 && count < MAX_DIGITS);
    for (int k = 0; k < count; k++) begin
      queue_digit(DIGIT_CHAR_W'(rev[count - 1 - k] + int'(CHAR_ZERO)),
                  k == count - 1, 1'b0);
    end
  endfunction

  // Mostly well-formed operands, some short ones, the rest corrupted bytes
  function automatic operand_chars_t random_operands();
    operand_chars_t chars;
    int             pick, hits;
    pick = $urandom_range(0, 99);
    for (int i = 0; i < 6; i++) chars[i] = CHAR_ZERO + CHAR_W'($urandom_range(0, 9));
    if (pick < 20) begin
      chars[5] = CHAR_ZERO;
      if (pick < 10) chars[4] = CHAR_ZERO;
    end else if (pick >= 97) begin
      for (int i = 0; i < 6; i++) chars[i] = CHAR_W'($urandom_range(0, 255));
    end else if (pick >= 80) begin
      hits = $urandom_range(1, 3);
      for (int i = 0; i < hits; i++) chars[$urandom_range(0, 5)] = CHAR_W'($urandom_range(0, 255));
    end
    return chars;
  endfunction

  // Offer one beat, after a random gap outside the back-to-back runs; called on a falling edge, returns on one
  task automatic send_operands(input row_kind_e kind, input operand_chars_t chars,
                               input logic [47:0] digits);
    int gap;
    gap = (items_sent % 100 < 30) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    a_hundreds_i <= chars[5];
    a_tens_i     <= chars[4];
    a_units_i    <= chars[3];
    b_hundreds_i <= chars[2];
    b_tens_i     <= chars[1];
    b_units_i    <= chars[0];
    do @(posedge clk_i); while (!in_ready_o);
    case (kind)
      ROW_DIGITS: begin
        for (int i = 5; i >= 0; i--) begin
          if (digits[i*8 +: 8] != 8'h00)
            queue_digit(digits[i*8 +: DIGIT_CHAR_W], i == 0, 1'b0);
        end
      end
      ROW_ERROR: queue_digit('0, 1'b1, 1'b1);
      default:   predict_product(chars);
    endcase
    items_sent++;
    @(negedge clk_i);
  endtask

  // Stimulus: reset, directed table, random items, drain
  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (directed_rows[r])
      send_operands(directed_rows[r].kind, directed_rows[r].chars, directed_rows[r].digits);
    repeat (RANDOM_ITEMS) send_operands(ROW_PREDICT, random_operands(), '0);
    in_valid_i <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d operand pairs (%0d from the directed table), checked %0d digit beats,",
             items_sent, DIRECTED_ITEMS, beats_seen);
    $display("of which %0d flagged bad input; %0d mismatches.", bad_beats, mismatches);
    if (mismatches == 0) begin
      $display("tb_ascii_decimal_multiplier_top: done, clean");
    end else begin
      $display("tb_ascii_decimal_multiplier_top: done, errors");
    end
    $finish;
  end

  // Receiver: random stalls per beat, one long hold to back the block up
  initial begin : drive_out_ready
    int stall;
    int taken;
    taken = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = (taken % 120 < 30) ? 0 : $urandom_range(0, 8);
      if (taken == HOLD_AFTER) stall = LONG_HOLD;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
      @(negedge clk_i);
    end
  end

  // Compare each accepted beat against the oldest expected digit
  always @(posedge clk_i) begin : check_digits
    product_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_seen++;
      if (bad_input_o) bad_beats++;
      if (pending_digits.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected beat digit=%0d last=%0b bad=%0b", $realtime,
                   digit_char_o, last_digit_o, bad_input_o);
      end else begin
        want = pending_digits.pop_front();
        if (want.digit !== digit_char_o || want.last !== last_digit_o ||
            want.bad !== bad_input_o) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: beat mismatch: exp digit=%0d last=%0b bad=%0b, got %0d %0b %0b",
                     $realtime, want.digit, want.last, want.bad,
                     digit_char_o, last_digit_o, bad_input_o);
        end
      end
    end
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("tb_ascii_decimal_multiplier_top: done, errors");
    $finish;
  end

endmodule
